// File: rtl/load_cell_tare_and_weight_defines.svh
// Assertion macros shared by the load cell tare and weight RTL.
// Both expect clk and rst_n in scope.
`ifndef LOAD_CELL_TARE_AND_WEIGHT_DEFINES_SVH
`define LOAD_CELL_TARE_AND_WEIGHT_DEFINES_SVH

// Same-cycle implication.
`define LCTW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("load cell assertion failed");

// Next-cycle implication.
`define LCTW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("load cell assertion failed");

`endif

// File: rtl/lctw_pkg.sv
`timescale 1ns / 1ps

package lctw_pkg;

    // Converter and tare sizing
    localparam int ADC_W        = 24;
    localparam int SUM_W        = 28;
    localparam int D_W          = SUM_W + 1;
    localparam int MAG_W        = SUM_W;
    localparam int TARE_SAMPLES = 10;
    localparam int CNT_W        = 4;

    // Gain: 0.598 uV per count over 25 uV per gram, Q20
    localparam int FRAC_BITS = 20;
    localparam int GAIN_W    = 15;
    localparam logic [GAIN_W-1:0] GAIN_Q20 = GAIN_W'(25082);

    // 0.005 V threshold in tare-scaled counts: d * 598 > TARE_SAMPLES * 5000000
    localparam int THRESH_D = (TARE_SAMPLES * 5000000) / 598;

    // Weight arithmetic
    localparam int Q_W      = GAIN_W + MAG_W - FRAC_BITS;
    localparam int G_W      = 20;
    localparam int KG_W     = 10;
    localparam int REM_W    = 10;
    localparam int KG_CORR  = 24;
    localparam int GRAMS_KG = 1000;
    localparam int GRAMS_10 = 10;
    localparam int KG_MAX   = 255;
    localparam int TENS_MAX = 99;

    typedef enum logic [1:0] {
        OP_TARE_AVG = 2'd0,
        OP_TARE_ONE = 2'd1,
        OP_MEASURE  = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic signed [ADC_W-1:0] adc_code;
    } in_item_t;

    typedef struct packed {
        logic [7:0] whole_kg;
        logic [6:0] weight_10g;
        logic       weight_updated;
        logic       tare_loaded;
    } out_item_t;

endpackage

// File: rtl/load_cell_tare_and_weight.sv
`timescale 1ns / 1ps
`include "load_cell_tare_and_weight_defines.svh"

// Channel   Handshake               Payload
// in        in_valid / in_ready     in_data  (op, adc_code)
// out       out_valid / out_ready   out_data (whole_kg, weight_10g, weight_updated, tare_loaded)
// cfg       cfg_we                  cfg_wdata (scan_enable)
//
// Tare, clear, ignored and below-threshold requests pass S_SCALE, S_EXEC and S_DONE before
// out_valid rises; a measurement past the threshold also runs the bit-serial multiplier,
// the shared restoring divider (grams, kg, kg again, tens of grams; tens are skipped when
// kilograms saturate) and one correction step. in_ready returns with out_valid, so requests
// never overlap; a result waiting on out_ready holds the next request in the final step.
// rst_n clears all state asynchronously: tare, held weight, scan enable and out_valid.
module load_cell_tare_and_weight
    import lctw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    localparam int STEP_W = $clog2(MAG_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_FIX,
        S_DONE
    } state_t;

    // Divider passes: grams from the scaled product, first kg split, kg split
    // of the corrected grams, tens of grams from the remainder.
    typedef enum logic [1:0] {
        PH_GRAMS,
        PH_KG0,
        PH_KG,
        PH_10G
    } div_ph_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic signed [ADC_W-1:0] code_reg, code_next;
    logic signed [SUM_W-1:0] x10_reg, x10_next;
    logic                    scan_en_reg, scan_en_next;
    logic signed [SUM_W-1:0] tare_sum_reg, tare_sum_next;
    logic signed [SUM_W-1:0] tare_acc_reg, tare_acc_next;
    logic [CNT_W-1:0]        tare_cnt_reg, tare_cnt_next;
    logic [7:0]              held_kg_reg, held_kg_next;
    logic [6:0]              held_10g_reg, held_10g_next;
    logic                    upd_reg, upd_next;
    logic                    loaded_reg, loaded_next;
    logic [MAG_W-1:0]        mq_reg, mq_next;
    logic [GAIN_W-1:0]       macc_reg, macc_next;
    logic [Q_W-1:0]          dvd_reg, dvd_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    div_ph_t                 ph_reg, ph_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [G_W-1:0]          g_reg, g_next;
    logic [KG_W-1:0]         kg_reg, kg_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg, out_data_next;

    // Datapath terms
    logic [CNT_W-1:0]        cnt_inc;
    logic signed [SUM_W-1:0] acc_inc;
    logic signed [D_W-1:0]   diff;
    logic [GAIN_W:0]         mul_sum;
    logic [REM_W:0]          trial;
    logic [REM_W-1:0]        divisor;
    logic [STEP_W-1:0]       div_last;
    logic                    div_ge;
    logic [REM_W-1:0]        rem_step;
    logic [Q_W-1:0]          dvd_step;
    logic [G_W-1:0]          g_corr;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cnt_inc = tare_cnt_reg + CNT_W'(1);
    assign acc_inc = tare_acc_reg + SUM_W'(code_reg);
    assign diff    = D_W'(x10_reg) - D_W'(tare_sum_reg);

    // One multiplier bit per cycle, LSB first; low product bits shift into mq.
    assign mul_sum = {1'b0, macc_reg} + (mq_reg[0] ? {1'b0, GAIN_Q20} : '0);

    // Restoring division, one quotient bit per cycle; dividends are left aligned.
    always_comb
    begin
        case (ph_reg)
            PH_GRAMS:
            begin
                divisor  = REM_W'(TARE_SAMPLES);
                div_last = STEP_W'(Q_W - 1);
            end
            PH_KG0, PH_KG:
            begin
                divisor  = REM_W'(GRAMS_KG);
                div_last = STEP_W'(G_W - 1);
            end
            default:
            begin
                divisor  = REM_W'(GRAMS_10);
                div_last = STEP_W'(REM_W - 1);
            end
        endcase
    end

    assign trial    = {rem_reg, dvd_reg[Q_W-1]};
    assign div_ge   = (trial >= {1'b0, divisor});
    assign rem_step = div_ge ? REM_W'(trial - {1'b0, divisor}) : REM_W'(trial);
    assign dvd_step = {dvd_reg[Q_W-2:0], div_ge};

    // Take out 24 g per whole kilogram
    assign g_corr = g_reg - G_W'(G_W'(kg_reg) * G_W'(KG_CORR));

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        code_next      = code_reg;
        x10_next       = x10_reg;
        scan_en_next   = cfg_we ? cfg_wdata : scan_en_reg;
        tare_sum_next  = tare_sum_reg;
        tare_acc_next  = tare_acc_reg;
        tare_cnt_next  = tare_cnt_reg;
        held_kg_next   = held_kg_reg;
        held_10g_next  = held_10g_reg;
        upd_next       = upd_reg;
        loaded_next    = loaded_reg;
        mq_next        = mq_reg;
        macc_next      = macc_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        ph_next        = ph_reg;
        step_next      = step_reg;
        g_next         = g_reg;
        kg_next        = kg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_data.op;
                    code_next   = in_data.adc_code;
                    upd_next    = 1'b0;
                    loaded_next = 1'b0;
                    state_next  = S_SCALE;
                end
            end

            S_SCALE:
            begin
                // Tare is kept as a sum of TARE_SAMPLES counts; wrap at the sum width
                x10_next   = SUM_W'(SUM_W'(code_reg) * SUM_W'(TARE_SAMPLES));
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_TARE_AVG:
                    begin
                        if ((cnt_inc >= CNT_W'(TARE_SAMPLES)) || (cnt_inc == '0))
                        begin
                            tare_sum_next = acc_inc;
                            tare_acc_next = '0;
                            tare_cnt_next = '0;
                            loaded_next   = 1'b1;
                        end
                        else
                        begin
                            tare_acc_next = acc_inc;
                            tare_cnt_next = cnt_inc;
                        end
                    end
                    OP_TARE_ONE:
                    begin
                        tare_sum_next = x10_reg;
                        tare_acc_next = '0;
                        tare_cnt_next = '0;
                        loaded_next   = 1'b1;
                    end
                    OP_MEASURE:
                    begin
                        if (scan_en_reg)
                        begin
                            upd_next = 1'b1;
                            if (diff > $signed(D_W'(THRESH_D)))
                            begin
                                mq_next    = MAG_W'(diff);
                                macc_next  = '0;
                                step_next  = '0;
                                state_next = S_MUL;
                            end
                            else
                            begin
                                held_kg_next  = '0;
                                held_10g_next = '0;
                            end
                        end
                    end
                    OP_CLEAR:
                    begin
                        held_kg_next  = '0;
                        held_10g_next = '0;
                        upd_next      = 1'b1;
                    end
                endcase
            end

            S_MUL:
            begin
                macc_next = mul_sum[GAIN_W:1];
                mq_next   = {mul_sum[0], mq_reg[MAG_W-1:1]};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    // Drop the Q20 fraction on the way into the divider
                    dvd_next   = {mul_sum[GAIN_W:1], mul_sum[0],
                                  mq_reg[MAG_W-1:MAG_W-(Q_W-GAIN_W)+1]};
                    rem_next   = '0;
                    step_next  = '0;
                    ph_next    = PH_GRAMS;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                dvd_next  = dvd_step;
                rem_next  = rem_step;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == div_last)
                begin
                    rem_next  = '0;
                    step_next = '0;
                    unique case (ph_reg)
                        PH_GRAMS:
                        begin
                            g_next   = dvd_step[G_W-1:0];
                            dvd_next = Q_W'(dvd_step[G_W-1:0]) << (Q_W - G_W);
                            ph_next  = PH_KG0;
                        end
                        PH_KG0:
                        begin
                            kg_next    = dvd_step[KG_W-1:0];
                            state_next = S_FIX;
                        end
                        PH_KG:
                        begin
                            if (dvd_step[KG_W-1:0] > KG_W'(KG_MAX))
                            begin
                                held_kg_next  = 8'(KG_MAX);
                                held_10g_next = 7'(TENS_MAX);
                                state_next    = S_DONE;
                            end
                            else
                            begin
                                kg_next  = dvd_step[KG_W-1:0];
                                dvd_next = Q_W'(rem_step) << (Q_W - REM_W);
                                ph_next  = PH_10G;
                            end
                        end
                        PH_10G:
                        begin
                            held_kg_next  = kg_reg[7:0];
                            held_10g_next = dvd_step[6:0];
                            state_next    = S_DONE;
                        end
                    endcase
                end
            end

            S_FIX:
            begin
                if (g_corr == '0)
                begin
                    held_kg_next  = '0;
                    held_10g_next = '0;
                    state_next    = S_DONE;
                end
                else
                begin
                    dvd_next   = Q_W'(g_corr) << (Q_W - G_W);
                    rem_next   = '0;
                    step_next  = '0;
                    ph_next    = PH_KG;
                    state_next = S_DIV;
                end
            end

            S_DONE:
            begin
                // Hold here until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.whole_kg       = held_kg_reg;
                    out_data_next.weight_10g     = held_10g_reg;
                    out_data_next.weight_updated = upd_reg;
                    out_data_next.tare_loaded    = loaded_reg;
                    out_valid_next               = 1'b1;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_TARE_AVG;
            code_reg      <= '0;
            x10_reg       <= '0;
            scan_en_reg   <= 1'b0;
            tare_sum_reg  <= '0;
            tare_acc_reg  <= '0;
            tare_cnt_reg  <= '0;
            held_kg_reg   <= '0;
            held_10g_reg  <= '0;
            upd_reg       <= 1'b0;
            loaded_reg    <= 1'b0;
            mq_reg        <= '0;
            macc_reg      <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            ph_reg        <= PH_GRAMS;
            step_reg      <= '0;
            g_reg         <= '0;
            kg_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            code_reg      <= code_next;
            x10_reg       <= x10_next;
            scan_en_reg   <= scan_en_next;
            tare_sum_reg  <= tare_sum_next;
            tare_acc_reg  <= tare_acc_next;
            tare_cnt_reg  <= tare_cnt_next;
            held_kg_reg   <= held_kg_next;
            held_10g_reg  <= held_10g_next;
            upd_reg       <= upd_next;
            loaded_reg    <= loaded_next;
            mq_reg        <= mq_next;
            macc_reg      <= macc_next;
            dvd_reg       <= dvd_next;
            rem_reg       <= rem_next;
            ph_reg        <= ph_next;
            step_reg      <= step_next;
            g_reg         <= g_next;
            kg_reg        <= kg_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Partial tare average never reaches the full sample count
    `LCTW_ASSERT_NOW(a_tare_cnt_range, 1'b1, tare_cnt_reg < CNT_W'(TARE_SAMPLES))
    // Held tens of grams stays a two-digit value
    `LCTW_ASSERT_NOW(a_tens_range, 1'b1, held_10g_reg <= 7'(TENS_MAX))
    // Divider remainder stays below the active divisor
    `LCTW_ASSERT_NOW(a_div_rem, state_reg == S_DIV, rem_reg < divisor)
    // A new result appears only out of the final sequencer step
    `LCTW_ASSERT_NEXT(a_result_src, !(state_reg == S_DONE), !$rose(out_valid_reg))

endmodule

// File: bench/load_cell_tare_and_weight_checker.sv
`timescale 1ns / 1ps

module load_cell_tare_and_weight_checker
    import lctw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    output int        errors,
    output int        outstanding
);

    // 0.005 V over 0.598 uV per count, kept as an exact ratio
    localparam longint THRESH_NUM = 598;
    localparam longint THRESH_DEN = 5000000;

    logic signed [SUM_W-1:0] tare_sum_q;
    logic signed [SUM_W-1:0] tare_acc_q;
    logic [CNT_W-1:0]        tare_cnt_q;
    logic [7:0]              kg_q;
    logic [6:0]              tens_q;
    logic                    scan_q;

    out_item_t expected_readings[$];
    out_item_t want;

    function automatic logic signed [SUM_W-1:0] wrap_sum(input longint v);
        return v[SUM_W-1:0];
    endfunction

    task automatic weigh_sample(input longint sample);
        longint d;
        longint grams;
        longint kg;
        longint tens;
        begin
            d = longint'(wrap_sum(sample * TARE_SAMPLES)) - longint'(tare_sum_q);
            kg_q   = 8'd0;
            tens_q = 7'd0;
            if (d * THRESH_NUM > longint'(TARE_SAMPLES) * THRESH_DEN) begin
                grams = (d * longint'(GAIN_Q20)) / (longint'(TARE_SAMPLES) <<< FRAC_BITS);
                grams = grams - (grams / GRAMS_KG) * KG_CORR;
                if (grams > 0) begin
                    kg = grams / GRAMS_KG;
                    if (kg > KG_MAX) begin
                        kg_q   = 8'(KG_MAX);
                        tens_q = 7'(TENS_MAX);
                    end
                    else begin
                        tens   = (grams % GRAMS_KG) / GRAMS_10;
                        kg_q   = kg[7:0];
                        tens_q = tens[6:0];
                    end
                end
            end
        end
    endtask

    task automatic predict_reading(input in_item_t req, output out_item_t res);
        longint sample;
        logic   updated;
        logic   loaded;
        begin
            sample  = longint'($signed(req.adc_code));
            updated = 1'b0;
            loaded  = 1'b0;
            case (req.op)
                OP_TARE_AVG: begin
                    tare_acc_q = wrap_sum(longint'(tare_acc_q) + sample);
                    tare_cnt_q = tare_cnt_q + 1'b1;
                    if (tare_cnt_q >= TARE_SAMPLES || tare_cnt_q == 0) begin
                        tare_sum_q = tare_acc_q;
                        tare_acc_q = '0;
                        tare_cnt_q = '0;
                        loaded     = 1'b1;
                    end
                end
                OP_TARE_ONE: begin
                    tare_sum_q = wrap_sum(sample * TARE_SAMPLES);
                    tare_acc_q = '0;
                    tare_cnt_q = '0;
                    loaded     = 1'b1;
                end
                OP_MEASURE: begin
                    if (scan_q) begin
                        weigh_sample(sample);
                        updated = 1'b1;
                    end
                end
                default: begin
                    kg_q    = 8'd0;
                    tens_q  = 7'd0;
                    updated = 1'b1;
                end
            endcase
            res.whole_kg       = kg_q;
            res.weight_10g     = tens_q;
            res.weight_updated = updated;
            res.tare_loaded    = loaded;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_sum_q  = '0;
            tare_acc_q  = '0;
            tare_cnt_q  = '0;
            kg_q        = '0;
            tens_q      = '0;
            scan_q      = 1'b0;
            errors      = 0;
            expected_readings.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                scan_q = cfg_wdata;
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (out_data.whole_kg !== want.whole_kg)
                    begin
                        $display("%0t: whole_kg expected %0d got %0d",
                                 $time, want.whole_kg, out_data.whole_kg);
                        errors++;
                    end
                    if (out_data.weight_10g !== want.weight_10g)
                    begin
                        $display("%0t: weight_10g expected %0d got %0d",
                                 $time, want.weight_10g, out_data.weight_10g);
                        errors++;
                    end
                    if (out_data.weight_updated !== want.weight_updated)
                    begin
                        $display("%0t: weight_updated expected %b got %b",
                                 $time, want.weight_updated, out_data.weight_updated);
                        errors++;
                    end
                    if (out_data.tare_loaded !== want.tare_loaded)
                    begin
                        $display("%0t: tare_loaded expected %b got %b",
                                 $time, want.tare_loaded, out_data.tare_loaded);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_reading(in_data, want);
                expected_readings.push_back(want);
            end
            outstanding = expected_readings.size();
        end
    end

endmodule

// File: bench/load_cell_tare_and_weight_tb.sv
`timescale 1ns / 1ps

module load_cell_tare_and_weight_tb;
    import lctw_pkg::*;

    localparam logic signed [ADC_W-1:0] ADC_MAX = 24'sh7FFFFF;
    localparam logic signed [ADC_W-1:0] ADC_MIN = 24'sh800000;

    // Sample offsets above the tare that matter for the threshold and the
    // kilogram correction (one count is about 0.02392 g).
    localparam longint THRESH_COUNTS = 8361;
    localparam longint ONE_KG_COUNTS = 41806;
    localparam longint KG_BOUNDARY_G = 1024;

    // Long receiver hold-off, in cycles; long enough to back up the input.
    localparam int HOLD_CYCLES = 400;

    // Pause after the last result before touching the register or ending.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 150;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;

    int errors;
    int outstanding;

    // Idle odds in percent for each side, changed per phase.
    int send_idle = 0;
    int recv_idle = 0;

    // Arm the one long hold-off; the receiver process counts it out.
    logic hold_req   = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left  = 0;

    int     requests_sent = 0;
    longint tare_base     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    load_cell_tare_and_weight dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    load_cell_tare_and_weight_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Receiver: drop ready at random, or hold it low for the whole
    // hold-off once it is armed.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            out_ready  <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Clamp a wide value into the converter range.
    function automatic logic signed [ADC_W-1:0] clip24(input longint v);
        if (v > longint'(ADC_MAX))
            return ADC_MAX;
        if (v < longint'(ADC_MIN))
            return ADC_MIN;
        return v[ADC_W-1:0];
    endfunction

    // Mix of full-range, small, mid-range and extreme readings.
    function automatic logic signed [ADC_W-1:0] rand_code();
        case ($urandom_range(0, 3))
            0: return ADC_W'($urandom());
            1: return clip24(longint'(int'($urandom_range(0, 4000)) - 2000));
            2: return $urandom_range(0, 1) ? ADC_MAX : ADC_MIN;
            default: return clip24(longint'(int'($urandom_range(0, 2000000)) - 1000000));
        endcase
    endfunction

    // Offer one request and hold it until it is taken. Returns at the edge
    // that accepted it, so the next call drives valid only once per step.
    task automatic put_request(input op_t op, input logic signed [ADC_W-1:0] code);
        begin
            while ($urandom_range(0, 99) < send_idle)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= '{op: op, adc_code: code};
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            requests_sent++;
        end
    endtask

    // Measure a sample aimed relative to the current tare: near the
    // threshold, within three kilograms, around a kilogram boundary,
    // below the tare, or anywhere up to saturation.
    task automatic put_weighing();
        longint off;
        longint k;
        begin
            case ($urandom_range(0, 4))
                0: off = THRESH_COUNTS - 6 + longint'($urandom_range(0, 12));
                1: off = longint'($urandom_range(0, 3 * ONE_KG_COUNTS));
                2: off = longint'($urandom_range(0, 11000000));
                3: off = -longint'($urandom_range(0, 100000));
                default:
                begin
                    k   = longint'($urandom_range(1, 260));
                    off = (k * KG_BOUNDARY_G * (longint'(1) <<< FRAC_BITS))
                          / longint'(GAIN_Q20)
                          + longint'(int'($urandom_range(0, 6)) - 3);
                end
            endcase
            put_request(OP_MEASURE, clip24(tare_base + off));
        end
    endtask

    // Wait until every result is back and the block has gone quiet.
    // Sample the count at the falling edge, away from the checker's update.
    task automatic wait_drained(input int settle);
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (outstanding != 0)
                @(negedge clk);
            repeat (settle) @(posedge clk);
        end
    endtask

    task automatic write_scan(input logic v);
        begin
            wait_drained(SETTLE_CYCLES);
            cfg_we    <= 1'b1;
            cfg_wdata <= v;
            @(posedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    // Random traffic: mostly tare-then-weigh sequences with random content,
    // plus weighings alone, clears, stray opcodes and tare averages that are cut short.
    task automatic run_segment(input int n);
        int target;
        int kind;
        int reps;
        logic signed [ADC_W-1:0] c;
        longint base;
        begin
            target = requests_sent + n;
            while (requests_sent < target)
            begin
                kind = $urandom_range(0, 9);
                if (kind <= 3)
                begin
                    base = longint'(rand_code());
                    repeat (TARE_SAMPLES)
                        put_request(OP_TARE_AVG,
                                    clip24(base + int'($urandom_range(0, 200)) - 100));
                    tare_base = base;
                    reps = $urandom_range(1, 5);
                    repeat (reps) put_weighing();
                end
                else if (kind <= 5)
                begin
                    c = rand_code();
                    put_request(OP_TARE_ONE, c);
                    tare_base = longint'(c);
                    reps = $urandom_range(1, 5);
                    repeat (reps) put_weighing();
                end
                else if (kind <= 7)
                begin
                    reps = $urandom_range(1, 6);
                    repeat (reps) put_weighing();
                end
                else if (kind == 8)
                    put_request(OP_CLEAR, ADC_W'($urandom()));
                else if ($urandom_range(0, 1))
                    put_request(op_t'(2'($urandom_range(0, 3))), ADC_W'($urandom()));
                else
                begin
                    // Abandon a partial average with a single tare or a reading.
                    reps = $urandom_range(1, TARE_SAMPLES - 1);
                    repeat (reps) put_request(OP_TARE_AVG, rand_code());
                    if ($urandom_range(0, 1))
                        put_request(OP_TARE_ONE, rand_code());
                    else
                        put_weighing();
                end
            end
        end
    endtask

    // Hard stop if the block hangs.
    initial
    begin
        #10_000_000;
        $display("load_cell_tare_and_weight_tb: errors");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle <= 11;
        recv_idle <= 64;

        // Directed: scan is off after reset, so the reading is ignored,
        // while a clear still goes through.
        put_request(OP_MEASURE, 24'sd1000);
        put_request(OP_CLEAR, ADC_MAX);
        write_scan(1'b1);

        // Zero tare: extremes, just at and just past the threshold, and
        // either side of the first kilogram correction.
        put_request(OP_TARE_ONE, 24'sd0);
        put_request(OP_MEASURE, ADC_MAX);
        put_request(OP_MEASURE, ADC_MIN);
        put_request(OP_MEASURE, 24'(THRESH_COUNTS));
        put_request(OP_MEASURE, 24'(THRESH_COUNTS + 1));
        put_request(OP_MEASURE, 24'(ONE_KG_COUNTS));
        put_request(OP_MEASURE, 24'sd42810);

        // Most negative tare: full scale saturates, the tare itself reads zero.
        put_request(OP_TARE_ONE, ADC_MIN);
        put_request(OP_MEASURE, ADC_MAX);
        put_request(OP_MEASURE, ADC_MIN);

        // A full average of alternating extremes loads on the last sample.
        repeat (TARE_SAMPLES / 2)
        begin
            put_request(OP_TARE_AVG, ADC_MAX);
            put_request(OP_TARE_AVG, ADC_MIN);
        end
        put_request(OP_MEASURE, 24'sd0);

        // A partial average is dropped by a single tare.
        repeat (3) put_request(OP_TARE_AVG, 24'sd100);
        put_request(OP_TARE_ONE, 24'sd50);
        put_request(OP_CLEAR, 24'sd0);
        tare_base = 50;

        // Phase one: sender idles a little, receiver a lot.
        write_scan(1'b1);
        run_segment(75);
        write_scan(1'b0);
        run_segment(30);

        // Phase two: the other way round.
        send_idle <= 64;
        recv_idle <= 11;
        write_scan(1'b1);
        run_segment(75);
        write_scan(1'b0);
        write_scan(1'b1);
        run_segment(70);

        // Phase three: no idling, with one long receiver hold-off while the
        // sender keeps offering requests.
        send_idle <= 0;
        recv_idle <= 0;
        write_scan(1'b1);
        hold_req <= 1'b1;
        run_segment(70);
        run_segment(70);

        wait_drained(TAIL_CYCLES);
        if (errors == 0 && outstanding == 0)
            $display("load_cell_tare_and_weight_tb: clean");
        else
            $display("load_cell_tare_and_weight_tb: errors");
        $finish;
    end

endmodule
